/* rtl/core/onewire_temperature_master_macros.svh */
// Assertion macros for the bus master checker.
`ifndef ONEWIRE_TEMPERATURE_MASTER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_MASTER_MACROS_SVH

// Property checked outside reset.
`define OWTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define OWTM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/owtm_pkg.sv */
package owtm_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int CFG_W          = 20;

    // request kinds; the class codes reuse the command values
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_RESET = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_TEMP  = 3'd4;

    localparam logic [2:0] CLS_TICK  = 3'd0;
    localparam logic [2:0] CLS_RESET = 3'd1;
    localparam logic [2:0] CLS_WRITE = 3'd2;
    localparam logic [2:0] CLS_READ  = 3'd3;
    localparam logic [2:0] CLS_TEMP  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PRES = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [2:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [2:0] CFG_PRES_WAIT   = 3'd1;
    localparam logic [2:0] CFG_RESET_TAIL  = 3'd2;
    localparam logic [2:0] CFG_WONE_LOW    = 3'd3;
    localparam logic [2:0] CFG_WZERO_LOW   = 3'd4;
    localparam logic [2:0] CFG_READ_LOW    = 3'd5;
    localparam logic [2:0] CFG_READ_SAMPLE = 3'd6;
    localparam logic [2:0] CFG_CONV_WAIT   = 3'd7;

    localparam logic [9:0]  RESET_LOW_DEF   = 10'd480;
    localparam logic [7:0]  PRES_WAIT_DEF   = 8'd70;
    localparam logic [9:0]  RESET_TAIL_DEF  = 10'd410;
    localparam logic [5:0]  WONE_LOW_DEF    = 6'd5;
    localparam logic [6:0]  WZERO_LOW_DEF   = 7'd60;
    localparam logic [5:0]  READ_LOW_DEF    = 6'd3;
    localparam logic [5:0]  READ_SAMPLE_DEF = 6'd10;
    localparam logic [19:0] CONV_WAIT_DEF   = 20'd750000;

    localparam logic [CFG_W-1:0] WONE_REL_US  = CFG_W'(55);
    localparam logic [CFG_W-1:0] WZERO_REL_US = CFG_W'(5);
    localparam logic [CFG_W-1:0] SLOT_TAIL_US = CFG_W'(50);

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    // power of two, pointers wrap naturally
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic       line_in;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic              presence;
        logic [7:0]        byte_read;
        logic signed [15:0] temperature_raw;
    } rsp_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       line_in;
        logic [7:0] data_byte;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

/* rtl/core/owtm_front.sv */
module owtm_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  owtm_pkg::req_t        req,
    output owtm_pkg::queue_head_t head,
    input  logic                  pop
);
    import owtm_pkg::*;

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             push;
    logic             do_pop;
    entry_t           in_entry;

    always_comb
    begin
        case (req.kind)
            KIND_RESET: in_entry.cls = CLS_RESET;
            KIND_WRITE: in_entry.cls = CLS_WRITE;
            KIND_READ:  in_entry.cls = CLS_READ;
            KIND_TEMP:  in_entry.cls = CLS_TEMP;
            default:    in_entry.cls = CLS_TICK;
        endcase
        in_entry.line_in   = req.line_in;
        in_entry.data_byte = req.data_byte;
    end

    assign req_stall = (count_reg == (QAW+1)'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign do_pop    = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/owtm_back.sv */
module owtm_back
#(
    parameter int TIMER_BITS = owtm_pkg::TIMER_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [owtm_pkg::CFG_W-1:0]     cfg_data,
    input  owtm_pkg::queue_head_t          head,
    output logic                           pop,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output owtm_pkg::rsp_t                 rsp
);
    import owtm_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_RLOW  = 4'd1;
    localparam logic [3:0] PH_RWAIT = 4'd2;
    localparam logic [3:0] PH_RTAIL = 4'd3;
    localparam logic [3:0] PH_WLOW  = 4'd4;
    localparam logic [3:0] PH_WHIGH = 4'd5;
    localparam logic [3:0] PH_SLOW  = 4'd6;
    localparam logic [3:0] PH_SWAIT = 4'd7;
    localparam logic [3:0] PH_STAIL = 4'd8;
    localparam logic [3:0] PH_CONV  = 4'd9;

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    function automatic logic [TIMER_BITS-1:0] sat_time(input logic [CFG_W-1:0] v);
        logic [31:0]           v32;
        logic [31:0]           hi;
        logic [TIMER_BITS-1:0] t;
        v32 = 32'(v);
        hi  = v32 >> TIMER_BITS;
        t   = (hi != 32'd0) ? TMAX : v32[TIMER_BITS-1:0];
        if (t == '0)
        begin
            t = TIMER_BITS'(1);
        end
        return t;
    endfunction

    // configuration
    logic [9:0]  reset_low_reg;
    logic [7:0]  pres_wait_reg;
    logic [9:0]  reset_tail_reg;
    logic [5:0]  wone_low_reg;
    logic [6:0]  wzero_low_reg;
    logic [5:0]  read_low_reg;
    logic [5:0]  read_sample_reg;
    logic [19:0] conv_wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg   <= RESET_LOW_DEF;
            pres_wait_reg   <= PRES_WAIT_DEF;
            reset_tail_reg  <= RESET_TAIL_DEF;
            wone_low_reg    <= WONE_LOW_DEF;
            wzero_low_reg   <= WZERO_LOW_DEF;
            read_low_reg    <= READ_LOW_DEF;
            read_sample_reg <= READ_SAMPLE_DEF;
            conv_wait_reg   <= CONV_WAIT_DEF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RESET_LOW:   reset_low_reg   <= cfg_data[9:0];
                CFG_PRES_WAIT:   pres_wait_reg   <= cfg_data[7:0];
                CFG_RESET_TAIL:  reset_tail_reg  <= cfg_data[9:0];
                CFG_WONE_LOW:    wone_low_reg    <= cfg_data[5:0];
                CFG_WZERO_LOW:   wzero_low_reg   <= cfg_data[6:0];
                CFG_READ_LOW:    read_low_reg    <= cfg_data[5:0];
                CFG_READ_SAMPLE: read_sample_reg <= cfg_data[5:0];
                CFG_CONV_WAIT:   conv_wait_reg   <= cfg_data[19:0];
                default:         conv_wait_reg   <= conv_wait_reg;
            endcase
        end
    end

    // engine state
    logic [3:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] time_left_reg, time_left_next;
    logic [15:0]           shift_reg, shift_next;
    logic [3:0]            bit_idx_reg, bit_idx_next;
    logic [3:0]            step_reg, step_next;
    logic [2:0]            act_cmd_reg, act_cmd_next;
    logic                  pres_reg, pres_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  slot_free;
    logic                  take;
    entry_t                e;
    logic                  complete;
    logic [TIMER_BITS-1:0] tl_dec;
    logic [3:0]            bit_inc;
    logic [TIMER_BITS-1:0] t_wone;
    logic [TIMER_BITS-1:0] t_wzero;
    logic [TIMER_BITS-1:0] t_rlow;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign take      = head.valid && slot_free;
    assign pop       = take;
    assign e         = head.entry;

    assign t_wone  = sat_time(CFG_W'(wone_low_reg));
    assign t_wzero = sat_time(CFG_W'(wzero_low_reg));
    assign t_rlow  = sat_time(CFG_W'(read_low_reg));

    always_comb
    begin
        phase_next     = phase_reg;
        time_left_next = time_left_reg;
        shift_next     = shift_reg;
        bit_idx_next   = bit_idx_reg;
        step_next      = step_reg;
        act_cmd_next   = act_cmd_reg;
        pres_next      = pres_reg;
        complete       = 1'b0;
        tl_dec         = (time_left_reg != '0) ? time_left_reg - 1'b1 : time_left_reg;
        bit_inc        = bit_idx_reg + 4'd1;
        rsp_next       = '0;

        if (e.cls != CLS_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rsp_next.status = ST_IGNORED;
            end
            else
            begin
                act_cmd_next = e.cls;
                step_next    = '0;
                case (e.cls)
                    CLS_WRITE:
                    begin
                        shift_next     = {8'h00, e.data_byte};
                        bit_idx_next   = '0;
                        phase_next     = PH_WLOW;
                        time_left_next = e.data_byte[0] ? t_wone : t_wzero;
                    end
                    CLS_READ:
                    begin
                        shift_next     = '0;
                        bit_idx_next   = '0;
                        phase_next     = PH_SLOW;
                        time_left_next = t_rlow;
                    end
                    default:
                    begin
                        phase_next     = PH_RLOW;
                        time_left_next = sat_time(CFG_W'(reset_low_reg));
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            time_left_next = tl_dec;
            if (tl_dec == '0)
            begin
                case (phase_reg)
                    PH_RLOW:
                    begin
                        phase_next     = PH_RWAIT;
                        time_left_next = sat_time(CFG_W'(pres_wait_reg));
                    end
                    PH_RWAIT:
                    begin
                        pres_next      = !e.line_in;
                        phase_next     = PH_RTAIL;
                        time_left_next = sat_time(CFG_W'(reset_tail_reg));
                    end
                    PH_WLOW:
                    begin
                        phase_next     = PH_WHIGH;
                        time_left_next = sat_time(shift_reg[0] ? WONE_REL_US : WZERO_REL_US);
                        shift_next     = {1'b0, shift_reg[15:1]};
                    end
                    PH_WHIGH:
                    begin
                        bit_idx_next = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            complete = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_WLOW;
                            time_left_next = shift_reg[0] ? t_wone : t_wzero;
                        end
                    end
                    PH_SLOW:
                    begin
                        phase_next     = PH_SWAIT;
                        time_left_next = sat_time(CFG_W'(read_sample_reg));
                    end
                    PH_SWAIT:
                    begin
                        shift_next     = {e.line_in, shift_reg[15:1]};
                        phase_next     = PH_STAIL;
                        time_left_next = sat_time(SLOT_TAIL_US);
                    end
                    PH_STAIL:
                    begin
                        bit_idx_next = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            complete = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_SLOW;
                            time_left_next = t_rlow;
                        end
                    end
                    PH_RTAIL, PH_CONV:
                    begin
                        complete = 1'b1;
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        time_left_next = '0;
                    end
                endcase

                if (complete)
                begin
                    case (act_cmd_reg)
                        CLS_RESET:
                        begin
                            phase_next        = PH_IDLE;
                            time_left_next    = '0;
                            rsp_next.done_res = 1'b1;
                            rsp_next.status   = pres_reg ? ST_OK : ST_NO_PRES;
                        end
                        CLS_WRITE:
                        begin
                            phase_next        = PH_IDLE;
                            time_left_next    = '0;
                            rsp_next.done_res = 1'b1;
                        end
                        CLS_READ:
                        begin
                            phase_next         = PH_IDLE;
                            time_left_next     = '0;
                            rsp_next.done_res  = 1'b1;
                            rsp_next.byte_read = shift_reg[15:8];
                        end
                        default:
                        begin
                            case (step_reg)
                                4'd0, 4'd4:
                                begin
                                    if (!pres_reg)
                                    begin
                                        phase_next        = PH_IDLE;
                                        time_left_next    = '0;
                                        rsp_next.done_res = 1'b1;
                                        rsp_next.status   = ST_NO_PRES;
                                    end
                                    else
                                    begin
                                        step_next      = step_reg + 4'd1;
                                        shift_next     = {8'h00, CMD_SKIP_ROM};
                                        bit_idx_next   = '0;
                                        phase_next     = PH_WLOW;
                                        time_left_next = CMD_SKIP_ROM[0] ? t_wone : t_wzero;
                                    end
                                end
                                4'd1:
                                begin
                                    step_next      = 4'd2;
                                    shift_next     = {8'h00, CMD_CONVERT};
                                    bit_idx_next   = '0;
                                    phase_next     = PH_WLOW;
                                    time_left_next = CMD_CONVERT[0] ? t_wone : t_wzero;
                                end
                                4'd2:
                                begin
                                    step_next      = 4'd3;
                                    phase_next     = PH_CONV;
                                    time_left_next = sat_time(conv_wait_reg);
                                end
                                4'd3:
                                begin
                                    step_next      = 4'd4;
                                    phase_next     = PH_RLOW;
                                    time_left_next = sat_time(CFG_W'(reset_low_reg));
                                end
                                4'd5:
                                begin
                                    step_next      = 4'd6;
                                    shift_next     = {8'h00, CMD_READ_SCRPD};
                                    bit_idx_next   = '0;
                                    phase_next     = PH_WLOW;
                                    time_left_next = CMD_READ_SCRPD[0] ? t_wone : t_wzero;
                                end
                                4'd6:
                                begin
                                    step_next      = 4'd7;
                                    shift_next     = '0;
                                    bit_idx_next   = '0;
                                    phase_next     = PH_SLOW;
                                    time_left_next = t_rlow;
                                end
                                4'd7:
                                begin
                                    step_next      = 4'd8;
                                    bit_idx_next   = '0;
                                    phase_next     = PH_SLOW;
                                    time_left_next = t_rlow;
                                end
                                default:
                                begin
                                    phase_next               = PH_IDLE;
                                    time_left_next           = '0;
                                    rsp_next.done_res        = 1'b1;
                                    rsp_next.temperature_raw = $signed(shift_reg);
                                end
                            endcase
                        end
                    endcase
                end
            end
        end

        rsp_next.drive_low = phase_next inside {PH_RLOW, PH_WLOW, PH_SLOW};
        rsp_next.busy_res  = (phase_next != PH_IDLE);
        rsp_next.presence  = pres_next;
    end

    assign rsp_valid_next = take || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            time_left_reg <= '0;
            shift_reg     <= '0;
            bit_idx_reg   <= '0;
            step_reg      <= '0;
            act_cmd_reg   <= CLS_TICK;
            pres_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                phase_reg     <= phase_next;
                time_left_reg <= time_left_next;
                shift_reg     <= shift_next;
                bit_idx_reg   <= bit_idx_next;
                step_reg      <= step_next;
                act_cmd_reg   <= act_cmd_next;
                pres_reg      <= pres_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/onewire_temperature_master.sv */
// Response: valid in the cycle after the engine takes the request off the queue.
// Throughput: one request per cycle while req_stall and rsp_stall stay low; the
// engine evaluates one tick per cycle, and a two-entry queue decouples intake
// from the engine's output register. Reset (rst_n low, asynchronous): bus engine
// idle, queue empty, no response pending, timing registers back to defaults.
module onewire_temperature_master
#(
    parameter int TIMER_BITS = owtm_pkg::TIMER_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  owtm_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output owtm_pkg::rsp_t             rsp,
    input  logic                       cfg_write,
    input  logic [2:0]                 cfg_index,
    input  logic [owtm_pkg::CFG_W-1:0] cfg_data
);
    import owtm_pkg::*;

    queue_head_t head;
    logic        pop;

    owtm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .head      (head),
        .pop       (pop)
    );

    owtm_back
    #(
        .TIMER_BITS (TIMER_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* rtl/core/owtm_checker.sv */
`include "onewire_temperature_master_macros.svh"

module owtm_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input owtm_pkg::rsp_t rsp
);
    import owtm_pkg::*;

    `OWTM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")
    `OWTM_ASSERT(a_done_idle, rsp_valid && rsp.done_res |-> !rsp.busy_res && !rsp.drive_low, "done while busy")
    `OWTM_ASSERT(a_ignored, rsp_valid && rsp.status == ST_IGNORED |-> rsp.busy_res && !rsp.done_res, "ignored request while idle")
    `OWTM_ASSERT_ALWAYS(a_drive_busy, rsp_valid && rsp.drive_low |-> rsp.busy_res, "bus driven while idle")

endmodule

bind onewire_temperature_master owtm_checker u_checker (.*);

/* tb/sv/tb_onewire_temperature_master.sv */
module tb_onewire_temperature_master;
    timeunit 1ns;
    timeprecision 1ps;

    import owtm_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int RANDOM_SETTINGS = 5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_REL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL,
        PH_CONVERT
    } bus_phase_e;

    typedef struct packed {
        bus_phase_e  phase;
        logic [19:0] time_left;
        logic [15:0] shift;
        logic [3:0]  bit_idx;
        logic [3:0]  step;
        logic [2:0]  cmd;
        logic        presence;
    } bus_state_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;
    logic             cfg_write = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [19:0] timing [8];
    bus_state_t  plan;
    bus_state_t  model;
    req_t        pending_reqs [$];
    rsp_t        expected_rsps [$];

    int  gen_cnt = 0;
    int  taken_cnt = 0;
    int  rsp_cnt = 0;
    int  done_cnt = 0;
    int  ignored_cnt = 0;
    int  input_stalls = 0;
    int  settings_cnt = 0;
    int  errors = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    logic hold_rsp = 1'b0;

    onewire_temperature_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- bus model

    // zero duration counts as one tick
    function automatic logic [19:0] span(input logic [19:0] v);
        return (v == '0) ? 20'd1 : v;
    endfunction

    function automatic void begin_reset(inout bus_state_t s);
        s.phase     = PH_RST_LOW;
        s.time_left = span(timing[CFG_RESET_LOW]);
    endfunction

    function automatic void begin_write_bit(inout bus_state_t s);
        s.phase     = PH_WR_LOW;
        s.time_left = span(s.shift[0] ? timing[CFG_WONE_LOW] : timing[CFG_WZERO_LOW]);
    endfunction

    function automatic void begin_write_byte(inout bus_state_t s, input logic [7:0] b);
        s.shift   = {8'h00, b};
        s.bit_idx = '0;
        begin_write_bit(s);
    endfunction

    function automatic void begin_read_bit(inout bus_state_t s);
        s.phase     = PH_RD_LOW;
        s.time_left = span(timing[CFG_READ_LOW]);
    endfunction

    function automatic void close_cmd(inout bus_state_t s, inout rsp_t r, input logic [1:0] st);
        s.phase     = PH_IDLE;
        s.time_left = '0;
        r.done_res  = 1'b1;
        r.status    = st;
    endfunction

    // one reset, byte or wait is over
    function automatic void end_of_op(inout bus_state_t s, inout rsp_t r);
        if (s.cmd == KIND_RESET)
            close_cmd(s, r, s.presence ? ST_OK : ST_NO_PRES);
        else if (s.cmd == KIND_WRITE)
            close_cmd(s, r, ST_OK);
        else if (s.cmd == KIND_READ)
        begin
            close_cmd(s, r, ST_OK);
            r.byte_read = s.shift[15:8];
        end
        else
        begin
            // temperature sequence steps
            case (s.step)
                4'd0, 4'd4:
                begin
                    if (!s.presence)
                        close_cmd(s, r, ST_NO_PRES);
                    else
                    begin
                        s.step = s.step + 4'd1;
                        begin_write_byte(s, CMD_SKIP_ROM);
                    end
                end
                4'd1:
                begin
                    s.step = 4'd2;
                    begin_write_byte(s, CMD_CONVERT);
                end
                4'd2:
                begin
                    s.step      = 4'd3;
                    s.phase     = PH_CONVERT;
                    s.time_left = span(timing[CFG_CONV_WAIT]);
                end
                4'd3:
                begin
                    s.step = 4'd4;
                    begin_reset(s);
                end
                4'd5:
                begin
                    s.step = 4'd6;
                    begin_write_byte(s, CMD_READ_SCRPD);
                end
                4'd6, 4'd7:
                begin
                    if (s.step == 4'd6)
                        s.shift = '0;
                    s.step    = s.step + 4'd1;
                    s.bit_idx = '0;
                    begin_read_bit(s);
                end
                default:
                begin
                    close_cmd(s, r, ST_OK);
                    r.temperature_raw = s.shift;
                end
            endcase
        end
    endfunction

    function automatic rsp_t predict_bus(inout bus_state_t s, input req_t q);
        rsp_t r;
        r = '0;
        if (q.kind >= KIND_RESET && q.kind <= KIND_TEMP)
        begin
            if (s.phase != PH_IDLE)
                r.status = ST_IGNORED;
            else
            begin
                s.cmd  = q.kind;
                s.step = '0;
                if (q.kind == KIND_WRITE)
                    begin_write_byte(s, q.data_byte);
                else if (q.kind == KIND_READ)
                begin
                    s.shift   = '0;
                    s.bit_idx = '0;
                    begin_read_bit(s);
                end
                else
                    begin_reset(s);
            end
        end
        else if (s.phase != PH_IDLE)
        begin
            if (s.time_left != '0)
                s.time_left = s.time_left - 20'd1;
            if (s.time_left == '0)
            begin
                case (s.phase)
                    PH_RST_LOW:
                    begin
                        s.phase     = PH_RST_WAIT;
                        s.time_left = span(timing[CFG_PRES_WAIT]);
                    end
                    PH_RST_WAIT:
                    begin
                        s.presence  = !q.line_in;
                        s.phase     = PH_RST_TAIL;
                        s.time_left = span(timing[CFG_RESET_TAIL]);
                    end
                    PH_WR_LOW:
                    begin
                        s.phase     = PH_WR_REL;
                        s.time_left = s.shift[0] ? WONE_REL_US : WZERO_REL_US;
                        s.shift     = s.shift >> 1;
                    end
                    PH_WR_REL:
                    begin
                        s.bit_idx = s.bit_idx + 4'd1;
                        if (s.bit_idx >= 4'd8)
                            end_of_op(s, r);
                        else
                            begin_write_bit(s);
                    end
                    PH_RD_LOW:
                    begin
                        s.phase     = PH_RD_WAIT;
                        s.time_left = span(timing[CFG_READ_SAMPLE]);
                    end
                    PH_RD_WAIT:
                    begin
                        s.shift     = {q.line_in, s.shift[15:1]};
                        s.phase     = PH_RD_TAIL;
                        s.time_left = SLOT_TAIL_US;
                    end
                    PH_RD_TAIL:
                    begin
                        s.bit_idx = s.bit_idx + 4'd1;
                        if (s.bit_idx >= 4'd8)
                            end_of_op(s, r);
                        else
                            begin_read_bit(s);
                    end
                    default:
                        end_of_op(s, r);
                endcase
            end
        end
        r.drive_low = (s.phase == PH_RST_LOW || s.phase == PH_WR_LOW || s.phase == PH_RD_LOW);
        r.busy_res  = (s.phase != PH_IDLE);
        r.presence  = s.presence;
        return r;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic int pick_idle(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 20)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d %s got %0h expected %0h",
                                      rsp_cnt, name, got, want));
    endtask

    task automatic offer(input logic [2:0] kind, input logic line, input logic [7:0] data);
        req_t q;
        rsp_t unused;
        q.kind      = kind;
        q.line_in   = line;
        q.data_byte = data;
        unused = predict_bus(plan, q);
        pending_reqs.push_back(q);
        gen_cnt++;
    endtask

    // one command plus the ticks that carry it to completion; pattern supplies
    // the sampled read bits, pres_a / pres_b the answer to the first / second reset
    task automatic run_command(input logic [2:0] kind, input logic [7:0] data,
                               input logic [15:0] pattern, input bit pres_a,
                               input bit pres_b, input int noise);
        logic       line;
        logic [2:0] k;
        offer(kind, 1'($urandom), data);
        while (plan.phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise)
                offer(3'($urandom_range(KIND_RESET, KIND_TEMP)), 1'($urandom), 8'($urandom));
            else
            begin
                line = 1'($urandom);
                if (plan.phase == PH_RST_WAIT && plan.time_left <= 20'd1)
                    line = !((plan.step < 4'd4) ? pres_a : pres_b);
                else if (plan.phase == PH_RD_WAIT && plan.time_left <= 20'd1)
                    line = pattern[{plan.step == 4'd8, plan.bit_idx[2:0]}];
                k = ($urandom_range(0, 99) < noise) ?
                    3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)) : KIND_TICK;
                offer(k, line, 8'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RESET_LOW, CFG_RESET_TAIL:               timing[idx] = val & 20'h003FF;
            CFG_PRES_WAIT:                               timing[idx] = val & 20'h000FF;
            CFG_WONE_LOW, CFG_READ_LOW, CFG_READ_SAMPLE: timing[idx] = val & 20'h0003F;
            CFG_WZERO_LOW:                               timing[idx] = val & 20'h0007F;
            default:                                     timing[idx] = val;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_timing(input logic [19:0] rlow, input logic [19:0] pwait,
                              input logic [19:0] rtail, input logic [19:0] wone,
                              input logic [19:0] wzero, input logic [19:0] rdlow,
                              input logic [19:0] rdsamp, input logic [19:0] conv);
        drain();
        write_reg(CFG_RESET_LOW, rlow);
        write_reg(CFG_PRES_WAIT, pwait);
        write_reg(CFG_RESET_TAIL, rtail);
        write_reg(CFG_WONE_LOW, wone);
        write_reg(CFG_WZERO_LOW, wzero);
        write_reg(CFG_READ_LOW, rdlow);
        write_reg(CFG_READ_SAMPLE, rdsamp);
        write_reg(CFG_CONV_WAIT, conv);
        settings_cnt++;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin : driver
        rsp_t want;
        logic accepted;
        if (rst_n)
        begin
            accepted = req_valid && !req_stall;
            if (req_valid && req_stall)
                input_stalls++;
            if (accepted)
            begin
                want = predict_bus(model, req);
                expected_rsps.push_back(want);
                taken_cnt++;
                if (want.done_res)
                    done_cnt++;
                if (want.status == ST_IGNORED)
                    ignored_cnt++;
            end
            if (!req_valid || accepted)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    gap_left  = pick_idle((taken_cnt / 300) % 4 == 3);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch($sformatf("response %0d arrived with none expected", rsp_cnt));
                else
                begin
                    want = expected_rsps.pop_front();
                    compare_field("drive_low", rsp.drive_low, want.drive_low);
                    compare_field("busy_res", rsp.busy_res, want.busy_res);
                    compare_field("done_res", rsp.done_res, want.done_res);
                    compare_field("status", rsp.status, want.status);
                    compare_field("presence", rsp.presence, want.presence);
                    compare_field("byte_read", rsp.byte_read, want.byte_read);
                    compare_field("temperature_raw", rsp.temperature_raw, want.temperature_raw);
                end
                rsp_cnt++;
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_idle((rsp_cnt / 250) % 3 == 1);
            rsp_stall <= hold_rsp || (stall_left > 0);
        end
    end

    // long response hold-off so the block backs up into its request input
    initial
    begin : backpressure
        while (taken_cnt < 400)
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin : watchdog
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin : stimulus
        int goal;
        int pick;
        int n;
        timing[CFG_RESET_LOW]   = 20'(RESET_LOW_DEF);
        timing[CFG_PRES_WAIT]   = 20'(PRES_WAIT_DEF);
        timing[CFG_RESET_TAIL]  = 20'(RESET_TAIL_DEF);
        timing[CFG_WONE_LOW]    = 20'(WONE_LOW_DEF);
        timing[CFG_WZERO_LOW]   = 20'(WZERO_LOW_DEF);
        timing[CFG_READ_LOW]    = 20'(READ_LOW_DEF);
        timing[CFG_READ_SAMPLE] = 20'(READ_SAMPLE_DEF);
        timing[CFG_CONV_WAIT]   = CONV_WAIT_DEF;
        plan  = '0;
        model = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // power-up timing
        settings_cnt = 1;
        offer(KIND_TICK, 1'b1, 8'h00);
        offer(KIND_SPARE_LO, 1'b0, 8'hFF);
        run_command(KIND_RESET, 8'h00, 16'h0000, 1'b1, 1'b1, 0);
        run_command(KIND_TEMP, 8'h5A, 16'h0000, 1'b0, 1'b0, 2);

        // all configurable durations zero, each taken as a single tick
        set_timing('0, '0, '0, '0, '0, '0, '0, '0);
        offer(KIND_SPARE_HI, 1'b1, 8'hA5);
        offer(KIND_TICK, 1'b0, 8'h5A);
        run_command(KIND_RESET, 8'h00, 16'h0000, 1'b1, 1'b1, 0);
        run_command(KIND_RESET, 8'hFF, 16'h0000, 1'b0, 1'b0, 0);
        run_command(KIND_WRITE, 8'h00, 16'h0000, 1'b1, 1'b1, 0);
        run_command(KIND_WRITE, 8'hFF, 16'h0000, 1'b1, 1'b1, 4);
        run_command(KIND_READ, 8'h00, 16'h0000, 1'b1, 1'b1, 0);
        run_command(KIND_READ, 8'h00, 16'hFFFF, 1'b1, 1'b1, 4);
        run_command(KIND_TEMP, 8'h00, 16'h7FFF, 1'b1, 1'b1, 0);
        run_command(KIND_TEMP, 8'h00, 16'h8000, 1'b1, 1'b1, 5);
        run_command(KIND_TEMP, 8'h00, 16'h0000, 1'b0, 1'b1, 0);
        run_command(KIND_TEMP, 8'h00, 16'h0000, 1'b1, 1'b0, 3);

        // random traffic over several short timing settings
        for (n = 0; n < RANDOM_SETTINGS; n++)
        begin
            set_timing(20'($urandom_range(1, 24)), 20'($urandom_range(1, 12)),
                       20'($urandom_range(1, 24)), 20'($urandom_range(1, 8)),
                       20'($urandom_range(1, 16)), 20'($urandom_range(1, 4)),
                       20'($urandom_range(1, 8)), 20'($urandom_range(1, 40)));
            goal = gen_cnt + RANDOM_ITEMS / RANDOM_SETTINGS;
            while (gen_cnt < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    repeat ($urandom_range(1, 4))
                        offer(($urandom_range(0, 1) != 0) ? KIND_TICK :
                              3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                              1'($urandom), 8'($urandom));
                else if (pick < 35)
                    run_command(KIND_RESET, 8'($urandom), 16'($urandom),
                                $urandom_range(0, 3) != 0, 1'b1, 3);
                else if (pick < 62)
                    run_command(KIND_WRITE, 8'($urandom), 16'($urandom), 1'b1, 1'b1, 3);
                else if (pick < 90)
                    run_command(KIND_READ, 8'($urandom), 16'($urandom), 1'b1, 1'b1, 3);
                else
                    run_command(KIND_TEMP, 8'($urandom), 16'($urandom),
                                $urandom_range(0, 9) < 6, $urandom_range(0, 9) < 7, 3);
            end
        end

        // widest values; data beyond each register's width is dropped
        set_timing('1, '1, '1, '1, '1, '1, '1, '1);
        run_command(KIND_RESET, 8'($urandom), 16'($urandom), 1'b1, 1'b1, 2);
        run_command(KIND_RESET, 8'($urandom), 16'($urandom), 1'b0, 1'b0, 0);
        run_command(KIND_WRITE, 8'($urandom), 16'($urandom), 1'b1, 1'b1, 2);
        run_command(KIND_READ, 8'($urandom), 16'($urandom), 1'b1, 1'b1, 2);
        run_command(KIND_TEMP, 8'($urandom), 16'($urandom), 1'b0, 1'b0, 2);

        drain();
        $display("Covered %0d requests over %0d timing settings: %0d commands done, %0d ignored.",
                 taken_cnt, settings_cnt, done_cnt, ignored_cnt);
        $display("Request input was stalled on %0d cycles by held-back responses.",
                 input_stalls);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/owtm_pkg.sv
rtl/core/owtm_front.sv
rtl/core/owtm_back.sv
rtl/core/onewire_temperature_master.sv
rtl/core/owtm_checker.sv
tb/sv/tb_onewire_temperature_master.sv
